// ----- hdl/matrix4x4_multiply_core_defines.svh -----
// ----------------------------------------------------------------------------
// matrix4x4_multiply_core_defines
// assertion macros shared by the matrix multiply core
// ----------------------------------------------------------------------------
`ifndef MATRIX4X4_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define M4X4_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matrix multiply core check failed");

// next-cycle implication, checked outside reset
`define M4X4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matrix multiply core check failed");

`endif

// ----- hdl/m4x4_pkg.sv -----
// ----------------------------------------------------------------------------
// m4x4_pkg
// types and constants for the fixed-point matrix multiply core
// ----------------------------------------------------------------------------
package m4x4_pkg;

  localparam int IDX_W          = 4;
  localparam int VAL_W          = 32;
  localparam int DIM_DEF        = 4;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index_res;
    logic signed [VAL_W-1:0] value_res;
    logic                    saturated;
    logic                    last;
  } out_item_t;

endpackage

// ----- hdl/matrix4x4_multiply_core.sv -----
// ----------------------------------------------------------------------------
// matrix4x4_multiply_core
// column-major Q16.16 matrix product on one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_item is taken at a clock edge with start high and busy
//   low. a load of the left or right matrix leaves busy low, so loads may
//   follow each other every cycle. a load at a position beyond the matrix,
//   or an unused operation code, changes nothing.
//   a compute item raises busy; one multiplier walks all DIM*DIM*DIM products
//   (64 for a 4x4), one per cycle through a read / multiply / accumulate
//   pipeline.
//   results: out_valid marks each product element for exactly one cycle, in
//   position order, the final one with out_item.last. busy falls in the
//   cycle the last element is shown. the receiver cannot stall; every
//   result transfer completes on its cycle.
//   the product is written into a second left bank and the banks swap at the
//   end, so products chain into the next compute.
//   reset: both matrices read as zero until written; no clearing pass.
// ----------------------------------------------------------------------------
`include "matrix4x4_multiply_core_defines.svh"

module matrix4x4_multiply_core #(
  parameter int DIM       = m4x4_pkg::DIM_DEF,
  parameter int FRAC_BITS = m4x4_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  m4x4_pkg::in_item_t  in_item,
  output logic                out_valid,
  output m4x4_pkg::out_item_t out_item
);
  import m4x4_pkg::*;

  localparam int NELEM = DIM * DIM;
  localparam int AW    = $clog2(NELEM);
  localparam int CW    = $clog2(DIM);
  localparam int ACC_W = 2 * VAL_W + CW + 1;
  localparam int EXT_W = 8;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [CW-1:0] CNT_MAX = CW'(DIM - 1);
  localparam logic [AW-1:0] K_LAST  = AW'(NELEM - 1);

  // sequencer
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] e_r, r_r, c_r;
  logic          bank_r;

  // storage
  logic [VAL_W-1:0] left_mem  [2*NELEM];
  logic [VAL_W-1:0] right_mem [NELEM];
  logic [NELEM-1:0] l_valid_r, r_valid_r;

  // pipeline
  logic             s1_vld_r, s1_first_r, s1_lastt_r;
  logic [AW-1:0]    s1_k_r;
  logic [VAL_W-1:0] lrd_r, rrd_r;
  logic             lvld_r, rvld_r;
  logic             s2_vld_r, s2_first_r, s2_lastt_r;
  logic [AW-1:0]    s2_k_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic             s3_vld_r, s3_lastt_r;
  logic [AW-1:0]    s3_k_r;
  logic signed [ACC_W-1:0] acc_r;

  logic             out_valid_r;
  out_item_t        out_item_r;

  // combinational
  logic                    accept, ld_left, ld_right, go;
  logic [EXT_W-1:0]        idx_ext;
  logic                    idx_ok;
  logic [AW-1:0]           ld_addr;
  logic                    issuing, issue_end;
  logic [AW-1:0]           laddr, raddr, kaddr;
  logic signed [VAL_W-1:0] op_a, op_b;
  logic                    emit, emit_last;
  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  logic [VAL_W-1:0]        sat_value;
  logic [EXT_W-1:0]        k_ext;

  assign accept  = start && !busy;
  assign idx_ext = EXT_W'(in_item.index);
  assign idx_ok  = idx_ext < EXT_W'(NELEM);
  assign ld_addr = idx_ext[AW-1:0];

  always_comb begin
    ld_left  = 1'b0;
    ld_right = 1'b0;
    go       = 1'b0;
    unique case (in_item.operation)
      OP_LOAD_LEFT:  ld_left  = accept && idx_ok;
      OP_LOAD_RIGHT: ld_right = accept && idx_ok;
      OP_COMPUTE:    go       = accept;
      default: ;
    endcase
  end

  assign issuing   = (state_r == ST_ISSUE);
  assign issue_end = issuing && (e_r == CNT_MAX) && (r_r == CNT_MAX) && (c_r == CNT_MAX);
  assign laddr     = AW'(r_r) + AW'(e_r) * AW'(DIM);
  assign raddr     = AW'(e_r) + AW'(c_r) * AW'(DIM);
  assign kaddr     = AW'(r_r) + AW'(c_r) * AW'(DIM);
  assign emit      = s3_vld_r && s3_lastt_r;
  assign emit_last = emit && (s3_k_r == K_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (go) state_nxt = ST_ISSUE;
      ST_ISSUE: if (issue_end) state_nxt = ST_DRAIN;
      ST_DRAIN: if (emit_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      e_r       <= '0;
      r_r       <= '0;
      c_r       <= '0;
      bank_r    <= 1'b0;
      l_valid_r <= '0;
      r_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        e_r <= '0;
        r_r <= '0;
        c_r <= '0;
      end else if (issuing) begin
        // inner loop over the dot-product term, then row, then column
        if (e_r == CNT_MAX) begin
          e_r <= '0;
          if (r_r == CNT_MAX) begin
            r_r <= '0;
            c_r <= c_r + 1'b1;
          end else begin
            r_r <= r_r + 1'b1;
          end
        end else begin
          e_r <= e_r + 1'b1;
        end
      end
      if (ld_left) l_valid_r[ld_addr] <= 1'b1;
      if (ld_right) r_valid_r[ld_addr] <= 1'b1;
      if (emit_last) begin
        // every product entry was written into the spare bank
        bank_r    <= ~bank_r;
        l_valid_r <= '1;
      end
    end
  end

  // left store: two banks, product goes to the spare one
  always_ff @(posedge clk) begin
    if (emit) begin
      left_mem[{~bank_r, s3_k_r}] <= sat_value;
    end else if (ld_left) begin
      left_mem[{bank_r, ld_addr}] <= in_item.value;
    end
    lrd_r  <= left_mem[{bank_r, laddr}];
    lvld_r <= l_valid_r[laddr];
  end

  always_ff @(posedge clk) begin
    if (ld_right) begin
      right_mem[ld_addr] <= in_item.value;
    end
    rrd_r  <= right_mem[raddr];
    rvld_r <= r_valid_r[raddr];
  end

  assign op_a = lvld_r ? signed'(lrd_r) : '0;
  assign op_b = rvld_r ? signed'(rrd_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issuing;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (e_r == '0);
    s1_lastt_r <= (e_r == CNT_MAX);
    s1_k_r     <= kaddr;
    s2_first_r <= s1_first_r;
    s2_lastt_r <= s1_lastt_r;
    s2_k_r     <= s1_k_r;
    prod_r     <= op_a * op_b;
    s3_lastt_r <= s2_lastt_r;
    s3_k_r     <= s2_k_r;
    if (s2_vld_r) begin
      acc_r <= s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // floor shift, then clip to 32 bits
  assign shifted   = acc_r >>> FRAC_BITS;
  assign fits      = (&shifted[ACC_W-1:VAL_W-1]) || !(|shifted[ACC_W-1:VAL_W-1]);
  assign sat_value = fits ? shifted[VAL_W-1:0] : (shifted[ACC_W-1] ? VAL_MIN : VAL_MAX);
  assign k_ext     = EXT_W'(s3_k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.index_res <= k_ext[IDX_W-1:0];
      out_item_r.value_res <= sat_value;
      out_item_r.saturated <= !fits;
      out_item_r.last      <= emit_last;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `M4X4_ASSERT_IMPLY(a_out_while_busy, out_valid, $past(busy))
  `M4X4_ASSERT_NEXT(a_compute_busy, start && !busy && in_item.operation == OP_COMPUTE, busy)
  `M4X4_ASSERT_IMPLY(a_last_frees, out_valid && out_item.last, !busy)
  `M4X4_ASSERT_NEXT(a_load_stays_idle, start && !busy && in_item.operation != OP_COMPUTE, !busy)

endmodule

// ----- verif/tb_matrix4x4_multiply_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_multiply_core
// self-checking bench for the Q16.16 4x4 matrix multiply core: loads and
// compute commands go in through the start/busy port, a scoreboard tracks
// both matrices and predicts every product element, including saturation,
// chaining of products into the left matrix and ignored operation codes
// ----------------------------------------------------------------------------
module tb_matrix4x4_multiply_core;
  import m4x4_pkg::*;

  localparam int         NELEM        = DIM_DEF * DIM_DEF;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         RAND_ITEMS   = 260;
  localparam int         CALM_TAIL    = 60;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         SHOW_LIMIT   = 10;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      took;

  class product_tracker;
    logic signed [VAL_W-1:0] left_m[NELEM];
    logic signed [VAL_W-1:0] right_m[NELEM];
    out_item_t               pending_products[$];
    int                      fail_count;

    function new();
      foreach (left_m[i]) begin
        left_m[i]  = '0;
        right_m[i] = '0;
      end
      fail_count = 0;
    endfunction

    function int outstanding();
      return pending_products.size();
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= SHOW_LIMIT) $display("%s", msg);
    endfunction

    // full-precision dot products, floor shift, then clip to 32 bits
    function void form_product();
      logic signed [VAL_W-1:0] prod[NELEM];
      logic signed [65:0]      acc;
      logic signed [65:0]      term;
      logic signed [65:0]      shifted;
      out_item_t               exp_item;
      int                      r;
      int                      c;
      for (int k = 0; k < NELEM; k++) begin
        r   = k % DIM_DEF;
        c   = k / DIM_DEF;
        acc = '0;
        for (int e = 0; e < DIM_DEF; e++) begin
          term = left_m[r + e * DIM_DEF] * right_m[e + c * DIM_DEF];
          acc  = acc + term;
        end
        shifted = acc >>> FRAC_BITS_DEF;
        exp_item.index_res = IDX_W'(k);
        exp_item.last      = (k == NELEM - 1);
        if (shifted[65:31] == '0 || shifted[65:31] == '1) begin
          exp_item.value_res = shifted[VAL_W-1:0];
          exp_item.saturated = 1'b0;
        end else begin
          exp_item.value_res = shifted[65] ? VAL_MIN : VAL_MAX;
          exp_item.saturated = 1'b1;
        end
        prod[k] = exp_item.value_res;
        pending_products.push_back(exp_item);
      end
      foreach (prod[k]) left_m[k] = prod[k];
    endfunction

    function void note_input(in_item_t it);
      case (it.operation)
        OP_LOAD_LEFT: begin
          if (it.index < NELEM) left_m[it.index] = it.value;
        end
        OP_LOAD_RIGHT: begin
          if (it.index < NELEM) right_m[it.index] = it.value;
        end
        OP_COMPUTE: begin
          form_product();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_products.size() == 0) begin
        flag($sformatf("unexpected product element: index %0d value %h sat %b last %b",
                       got.index_res, got.value_res, got.saturated, got.last));
        return;
      end
      want = pending_products.pop_front();
      if (got.index_res !== want.index_res || got.value_res !== want.value_res ||
          got.saturated !== want.saturated || got.last !== want.last) begin
        flag($sformatf({"product element mismatch: expected index %0d value %h sat %b ",
                        "last %b, got index %0d value %h sat %b last %b"},
                       want.index_res, want.value_res, want.saturated, want.last,
                       got.index_res, got.value_res, got.saturated, got.last));
      end
    endfunction
  endclass

  product_tracker sb;

  matrix4x4_multiply_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // results are checked before a transfer at the same edge is noted
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
    if (rst_n && start && !busy) sb.note_input(in_item);
    took <= rst_n && start && !busy;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("tb_matrix4x4_multiply_core failed");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(logic [1:0] op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    in_item_t it;
    it.operation = op;
    it.index     = idx;
    it.value     = val;
    start   <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (!took);
  endtask

  task automatic wait_for_products();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return VAL_MAX;
        2:       return VAL_MIN;
        3:       return '1;
        4:       return 32'h0001_0000;
        default: return 32'hffff_0000;
      endcase
    end
    if (sel <= 2) return $urandom();
    // mostly small magnitudes, within about +-4.0
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  initial begin
    int unsigned useful;
    int unsigned pick;
    bit          allow_idle;
    logic [1:0]  op;

    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // product of the cleared matrices
    send_item(OP_COMPUTE, '0, '0);
    // most negative squared plus most positive squared clips high
    send_item(OP_LOAD_LEFT,  4'd0, VAL_MIN);
    send_item(OP_LOAD_RIGHT, 4'd0, VAL_MIN);
    send_item(OP_LOAD_LEFT,  4'd4, VAL_MAX);
    send_item(OP_LOAD_RIGHT, 4'd1, VAL_MAX);
    // large negative sum clips low
    send_item(OP_LOAD_LEFT,  4'd1, VAL_MAX);
    // one times the minimum lands exactly on the lower bound
    send_item(OP_LOAD_LEFT,  4'd2, 32'h0001_0000);
    send_item(OP_LOAD_LEFT,  4'd3, '1);
    send_item(OP_LOAD_LEFT,  4'd15, 32'h5555_aaaa);
    send_item(OP_LOAD_RIGHT, 4'd15, 32'haaaa_5555);
    send_item(OP_LOAD_RIGHT, 4'd10, 32'hffff_8000);
    send_item(OP_COMPUTE, '0, '0);
    // unused code changes nothing
    send_item(OP_UNUSED, 4'd7, 32'h1234_5678);
    // compute ignores its index and value, and chains on the last product
    send_item(OP_COMPUTE, 4'hf, VAL_MIN);
    send_item(OP_LOAD_RIGHT, 4'd5, 32'h0002_0000);
    send_item(OP_COMPUTE, 4'ha, VAL_MAX);
    wait_for_products();

    useful = 0;
    while (useful < RAND_ITEMS) begin
      allow_idle = (useful < RAND_ITEMS - CALM_TAIL) && ((useful / 40) % 3 != 2);
      if (useful == RAND_ITEMS / 2) begin
        wait_for_products();
      end else if (allow_idle && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 42)      op = OP_LOAD_LEFT;
      else if (pick < 84) op = OP_LOAD_RIGHT;
      else if (pick < 95) op = OP_COMPUTE;
      else                op = OP_UNUSED;
      send_item(op, IDX_W'($urandom_range(0, NELEM - 1)), pick_value());
      if (op != OP_UNUSED) useful++;
    end
    send_item(OP_COMPUTE, '0, '0);

    wait_for_products();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("tb_matrix4x4_multiply_core passed");
    end else begin
      $display("tb_matrix4x4_multiply_core failed");
    end
    $finish;
  end

endmodule
